@@ design/ils_pkg.sv @@
// Shared types, field layout and codes for the indexed list store.
package ils_pkg;

   localparam int CAPACITY_DEF   = 1024;
   localparam int VALUE_BITS_DEF = 16;

   localparam int MODE_W   = 3;
   localparam int POS_W    = 10;
   localparam int VALUE_W  = 16;
   localparam int LENGTH_W = 11;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   localparam int REQ_MODE_LSB  = 0;
   localparam int REQ_POS_LSB   = REQ_MODE_LSB + MODE_W;
   localparam int REQ_VALUE_LSB = REQ_POS_LSB + POS_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_READ   = 3'd0,
      MODE_HEAD   = 3'd1,
      MODE_TAIL   = 3'd2,
      MODE_INSERT = 3'd3,
      MODE_DELETE = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // packed from the top bit down: length, status, found, read_value
   typedef struct packed {
      logic [LENGTH_W-1:0] length;
      status_type          status;
      logic                found;
      logic [VALUE_W-1:0]  read_value;
   } rsp_type;

   localparam int RSP_PAD_W = RSP_DATA_W - $bits(rsp_type);

endpackage

@@ design/indexed_list_store.sv @@
// Top level of the indexed list store: entry RAM, sequencer and response register.
//
//  channel | ports          | payload
//  --------+----------------+--------------------------------------------------
//  request | req_t*         | tdata: mode[2:0] position[12:3] value[28:13]
//  result  | rsp_t*         | tdata: read_value[15:0] found[16] status[18:17]
//          |                |        length[29:19]
//
// A read, an add at the tail, an out-of-range or full request and an unused mode
// move no entries. Insert shifts the entries from the position up and then writes
// the new value; delete shifts the entries past the hole down. The single write port
// of the entry RAM moves one entry per cycle. Reset clears the length but not the
// entries, which need no clearing. A response waits in its register while the next
// request is accepted; the sequencer stalls at its end until that register frees up.
module indexed_list_store #(
   parameter int CAPACITY   = ils_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = ils_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ils_pkg::REQ_DATA_W-1:0]  req_tdata,  // mode, position, value, pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ils_pkg::RSP_DATA_W-1:0]  rsp_tdata   // read_value, found, status, length, pad
);

   import ils_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [VALUE_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   logic [VALUE_BITS-1:0] ram_rd_data;

   logic                  res_valid;
   rsp_type               res_data;
   logic                  res_take;
   logic                  out_free;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   ils_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ils_ctrl #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_mode     (req_tdata[REQ_MODE_LSB +: MODE_W]),
      .req_position (req_tdata[REQ_POS_LSB +: POS_W]),
      .req_value    (req_tdata[REQ_VALUE_LSB +: VALUE_W]),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .res_valid    (res_valid),
      .res_data     (res_data),
      .res_take     (res_take)
   );

   // load the response register when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign res_take = res_valid && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_data;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ff};

endmodule

@@ design/ils_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module ils_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 1024,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/ils_ctrl.sv @@
// Sequencer: decodes a request, walks the entry RAM to shift entries, builds the result.
module ils_ctrl #(
   parameter  int CAPACITY   = 1024,
   parameter  int VALUE_BITS = 16,
   localparam int AW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW         = $clog2(CAPACITY + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [ils_pkg::MODE_W-1:0]  req_mode,
   input  logic [ils_pkg::POS_W-1:0]   req_position,
   input  logic [ils_pkg::VALUE_W-1:0] req_value,
   output logic                     ram_wr_en,
   output logic [AW-1:0]            ram_wr_addr,
   output logic [VALUE_BITS-1:0]    ram_wr_data,
   output logic                     ram_rd_en,
   output logic [AW-1:0]            ram_rd_addr,
   input  logic [VALUE_BITS-1:0]    ram_rd_data,
   output logic                     res_valid,
   output ils_pkg::rsp_type         res_data,
   input  logic                     res_take
);

   import ils_pkg::*;

   localparam int PW = CW + POS_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_SHIFT,
      ST_DRAIN,
      ST_PUT,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [AW-1:0]        end_ff, end_in;
   logic [AW-1:0]        wa_ff, wa_in;
   logic [AW-1:0]        tgt_ff, tgt_in;
   logic                 up_ff, up_in;
   logic                 pend_ff, pend_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   rsp_type              res_ff, res_in;

   logic [PW-1:0]        pos_w;
   logic [PW-1:0]        cnt_w;
   logic [PW-1:0]        cnt_m1_w;
   logic [PW-1:0]        put_w;
   logic                 full;
   logic [CW+LENGTH_W-1:0] len_ext;
   logic [VALUE_BITS+VALUE_W-1:0] val_ext;
   logic [VALUE_BITS+VALUE_W-1:0] rd_ext;

   assign pos_w    = {{CW{1'b0}}, req_position};
   assign cnt_w    = {{POS_W{1'b0}}, count_ff};
   assign cnt_m1_w = cnt_w - PW'(1);
   assign full     = (count_ff == CW'(CAPACITY));
   assign val_ext  = {{VALUE_BITS{1'b0}}, req_value};
   assign rd_ext   = {{VALUE_W{1'b0}}, ram_rd_data};

   always_comb begin
      case (req_mode)
         MODE_HEAD: put_w = '0;
         MODE_TAIL: put_w = cnt_w;
         default:   put_w = pos_w;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_FINISH);
   assign res_data  = res_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      end_in      = end_ff;
      wa_in       = wa_ff;
      tgt_in      = tgt_ff;
      up_in       = up_ff;
      pend_in     = 1'b0;
      val_in      = val_ff;
      res_in      = res_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wa_ff;
      ram_wr_data = ram_rd_data;
      len_ext     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in.read_value = '0;
               res_in.found      = 1'b0;
               res_in.status     = STAT_DONE;
               state_in          = ST_FINISH;
               case (req_mode)
                  MODE_READ: begin
                     if (pos_w < cnt_w) begin
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = pos_w[AW-1:0];
                        res_in.found = 1'b1;
                        state_in     = ST_READ_WAIT;
                     end else begin
                        res_in.status = STAT_RANGE;
                     end
                  end
                  MODE_HEAD, MODE_TAIL, MODE_INSERT: begin
                     if (put_w > cnt_w) begin
                        res_in.status = STAT_RANGE;
                     end else if (full) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        count_in = count_ff + CW'(1);
                        tgt_in   = put_w[AW-1:0];
                        val_in   = val_ext[VALUE_BITS-1:0];
                        up_in    = 1'b1;
                        if (put_w == cnt_w) begin
                           state_in = ST_PUT;
                        end else begin
                           // move entries up, starting from the tail
                           idx_in   = cnt_m1_w[AW-1:0];
                           end_in   = put_w[AW-1:0];
                           state_in = ST_SHIFT;
                        end
                     end
                  end
                  MODE_DELETE: begin
                     if (pos_w >= cnt_w) begin
                        res_in.status = STAT_RANGE;
                     end else begin
                        count_in = count_ff - CW'(1);
                        up_in    = 1'b0;
                        if (pos_w != cnt_m1_w) begin
                           // move entries down, starting just past the hole
                           idx_in   = pos_w[AW-1:0] + AW'(1);
                           end_in   = cnt_m1_w[AW-1:0];
                           state_in = ST_SHIFT;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               len_ext          = {{LENGTH_W{1'b0}}, count_in};
               res_in.length    = len_ext[LENGTH_W-1:0];
            end
         end
         ST_READ_WAIT: begin
            res_in.read_value = rd_ext[VALUE_W-1:0];
            state_in          = ST_FINISH;
         end
         ST_SHIFT: begin
            // read one entry ahead while writing back the previous one
            ram_rd_en = 1'b1;
            ram_wr_en = pend_ff;
            pend_in   = 1'b1;
            wa_in     = up_ff ? (idx_ff + AW'(1)) : (idx_ff - AW'(1));
            if (idx_ff == end_ff) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = up_ff ? (idx_ff - AW'(1)) : (idx_ff + AW'(1));
            end
         end
         ST_DRAIN: begin
            ram_wr_en = 1'b1;
            state_in  = up_ff ? ST_PUT : ST_FINISH;
         end
         ST_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = tgt_ff;
            ram_wr_data = val_ff;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      idx_ff <= idx_in;
      end_ff <= end_in;
      wa_ff  <= wa_in;
      tgt_ff <= tgt_in;
      up_ff  <= up_in;
      val_ff <= val_in;
      res_ff <= res_in;
   end

endmodule
